@@ sv/rpn_pkg.sv @@
// Shared types, constants and helpers of the postfix expression evaluator.
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 16;
  localparam int DIV_W       = Q_W + FRAC_W;
  localparam int SAT_W       = DIV_W + 1;
  localparam int STEP_W      = $clog2(DIV_W);

  typedef enum logic [2:0] {
    OP_NUM = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_END = 3'd5
  } tok_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FINAL    = 3'd1,
    ST_FEW      = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_BADEND   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_LOAD,
    CS_EXEC,
    CS_RESP
  } ctl_state_e;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_FIN
  } alu_state_e;

  typedef struct packed {
    logic [2:0]            op;
    logic signed [Q_W-1:0] value;
  } rpn_in_t;

  typedef struct packed {
    logic [2:0]            status;
    logic signed [Q_W-1:0] result_value;
  } rpn_out_t;

  typedef struct packed {
    logic            wr_en;
    logic [SP_W-1:0] wr_addr;
    logic [Q_W-1:0]  wr_data;
    logic            rd_en;
    logic [SP_W-1:0] rd_addr;
  } stack_req_t;

  typedef struct packed {
    logic                  start;
    alu_op_e               op;
    logic signed [Q_W-1:0] a;
    logic signed [Q_W-1:0] b;
  } alu_req_t;

  // Clamps a wide signed value to the Q16.16 range.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = {{(SAT_W - Q_W + 1){1'b0}}, {(Q_W - 1){1'b1}}};
    lo = {{(SAT_W - Q_W + 1){1'b1}}, {(Q_W - 1){1'b0}}};
    if (v > hi) begin
      return {1'b0, {(Q_W - 1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(Q_W - 1){1'b0}}};
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

endpackage

@@ sv/rpn_stack.sv @@
// Operand stack memory with one write port and one registered read port.
module rpn_stack (
  input  logic                       clk_i,
  input  rpn_pkg::stack_req_t        req_i,
  output logic [rpn_pkg::Q_W-1:0]    rd_data_o
);

  logic [rpn_pkg::Q_W-1:0] mem_q [rpn_pkg::STACK_DEPTH];
  logic [rpn_pkg::Q_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/rpn_alu.sv @@
// Shared arithmetic unit: saturating add and subtract, multiply, and bit-serial divide.
module rpn_alu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rpn_pkg::alu_req_t              req_i,
  output logic                           done_o,
  output logic signed [rpn_pkg::Q_W-1:0] result_o
);

  rpn_pkg::alu_state_e state_q, state_d;

  logic signed [2*rpn_pkg::Q_W-1:0] prod_q, prod_d;
  logic [rpn_pkg::Q_W-1:0]          rem_q, rem_d;
  logic [rpn_pkg::DIV_W-1:0]        dvd_q, dvd_d;
  logic [rpn_pkg::Q_W-1:0]          dvs_q, dvs_d;
  logic                             neg_q, neg_d;
  logic [rpn_pkg::STEP_W-1:0]       step_q, step_d;
  logic signed [rpn_pkg::Q_W-1:0]   res_q, res_d;
  logic                             done_q, done_d;

  logic [rpn_pkg::Q_W-1:0]          a_mag;
  logic [rpn_pkg::Q_W-1:0]          b_mag;
  logic [rpn_pkg::Q_W:0]            trial;
  logic [rpn_pkg::Q_W:0]            diff;
  logic signed [rpn_pkg::SAT_W-1:0] quo;

  assign a_mag = req_i.a[rpn_pkg::Q_W-1] ? (~req_i.a + 1'b1) : req_i.a;
  assign b_mag = req_i.b[rpn_pkg::Q_W-1] ? (~req_i.b + 1'b1) : req_i.b;
  assign trial = {rem_q, dvd_q[rpn_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign quo   = {1'b0, dvd_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpn_pkg::AS_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == rpn_pkg::ALU_MUL) begin
            state_d = rpn_pkg::AS_MUL;
          end else if (req_i.op == rpn_pkg::ALU_DIV) begin
            state_d = rpn_pkg::AS_DIV;
          end
        end
      end
      rpn_pkg::AS_MUL: state_d = rpn_pkg::AS_IDLE;
      rpn_pkg::AS_DIV: begin
        if (step_q == rpn_pkg::STEP_W'(rpn_pkg::DIV_W - 1)) begin
          state_d = rpn_pkg::AS_FIN;
        end
      end
      rpn_pkg::AS_FIN: state_d = rpn_pkg::AS_IDLE;
      default: state_d = rpn_pkg::AS_IDLE;
    endcase
  end

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    step_d = step_q;
    res_d  = res_q;
    done_d = 1'b0;
    unique case (state_q)
      rpn_pkg::AS_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            rpn_pkg::ALU_ADD: begin
              res_d  = rpn_pkg::sat_q(rpn_pkg::SAT_W'(req_i.a) + rpn_pkg::SAT_W'(req_i.b));
              done_d = 1'b1;
            end
            rpn_pkg::ALU_SUB: begin
              res_d  = rpn_pkg::sat_q(rpn_pkg::SAT_W'(req_i.a) - rpn_pkg::SAT_W'(req_i.b));
              done_d = 1'b1;
            end
            rpn_pkg::ALU_MUL: begin
              prod_d = req_i.a * req_i.b;
            end
            rpn_pkg::ALU_DIV: begin
              rem_d  = '0;
              dvd_d  = {a_mag, {rpn_pkg::FRAC_W{1'b0}}};
              dvs_d  = b_mag;
              neg_d  = req_i.a[rpn_pkg::Q_W-1] ^ req_i.b[rpn_pkg::Q_W-1];
              step_d = '0;
            end
            default: ;
          endcase
        end
      end
      rpn_pkg::AS_MUL: begin
        res_d  = rpn_pkg::sat_q(rpn_pkg::SAT_W'(prod_q >>> rpn_pkg::FRAC_W));
        done_d = 1'b1;
      end
      rpn_pkg::AS_DIV: begin
        if (!diff[rpn_pkg::Q_W]) begin
          rem_d = diff[rpn_pkg::Q_W-1:0];
          dvd_d = {dvd_q[rpn_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_d = trial[rpn_pkg::Q_W-1:0];
          dvd_d = {dvd_q[rpn_pkg::DIV_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
      end
      rpn_pkg::AS_FIN: begin
        res_d  = rpn_pkg::sat_q(neg_q ? -quo : quo);
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpn_pkg::AS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    step_q <= step_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ sv/postfix_expression_evaluator.sv @@
// Top level of the postfix expression evaluator: token sequencer, stack and shared unit.
//
//   channel | direction | handshake              | beat
//   in      | input     | in_valid_i, in_stall_o   | rpn_in_t  (op, value)
//   out     | output    | out_valid_o, out_stall_i | rpn_out_t (status, result_value)
//
// A number, end, error or unknown token goes from decode straight to the response state;
// add, subtract, multiply and divide that pass their checks go through decode, load and
// execute first. Divide runs the 48-step restoring divider that produces one quotient bit
// per cycle. Each result is loaded into the output register from the response state.
// One token is in flight at a time; the input stalls until its result is in the output register.
// Reset empties the stack at once; the stack memory itself is not cleared.
// A stalled output holds its beat, and the next result waits behind it.
module postfix_expression_evaluator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rpn_pkg::rpn_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rpn_pkg::rpn_out_t out_data_o
);

  rpn_pkg::ctl_state_e state_q, state_d;

  rpn_pkg::rpn_in_t               tok_q, tok_d;
  logic [rpn_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [rpn_pkg::Q_W-1:0] tos_q, tos_d;
  rpn_pkg::rpn_out_t              rsp_q, rsp_d;
  rpn_pkg::rpn_out_t              out_q, out_d;
  logic                           out_valid_q, out_valid_d;

  rpn_pkg::stack_req_t            stk_req;
  logic [rpn_pkg::Q_W-1:0]        stk_rd_data;
  rpn_pkg::alu_req_t              alu_req;
  logic                           alu_done;
  logic signed [rpn_pkg::Q_W-1:0] alu_result;
  logic [rpn_pkg::SP_W-1:0]       below_idx;
  logic                           out_free;
  logic                           bin_ok;

  assign below_idx = rpn_pkg::SP_W'(cnt_q - rpn_pkg::CNT_W'(2));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign bin_ok    = (cnt_q >= rpn_pkg::CNT_W'(2))
                     && !((tok_q.op == rpn_pkg::OP_DIV) && (tos_q == '0));

  rpn_stack u_stack (
    .clk_i     (clk_i),
    .req_i     (stk_req),
    .rd_data_o (stk_rd_data)
  );

  rpn_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpn_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          state_d = rpn_pkg::CS_DECODE;
        end
      end
      rpn_pkg::CS_DECODE: begin
        unique case (tok_q.op) inside
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
            state_d = bin_ok ? rpn_pkg::CS_LOAD : rpn_pkg::CS_RESP;
          end
          default: state_d = rpn_pkg::CS_RESP;
        endcase
      end
      rpn_pkg::CS_LOAD: state_d = rpn_pkg::CS_EXEC;
      rpn_pkg::CS_EXEC: begin
        if (alu_done) begin
          state_d = rpn_pkg::CS_RESP;
        end
      end
      rpn_pkg::CS_RESP: begin
        if (out_free) begin
          state_d = rpn_pkg::CS_IDLE;
        end
      end
      default: state_d = rpn_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    tok_d       = tok_q;
    cnt_d       = cnt_q;
    tos_d       = tos_q;
    rsp_d       = rsp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    stk_req     = '0;
    alu_req.start = 1'b0;
    alu_req.a     = stk_rd_data;
    alu_req.b     = tos_q;
    unique case (tok_q.op) inside
      rpn_pkg::OP_SUB: alu_req.op = rpn_pkg::ALU_SUB;
      rpn_pkg::OP_MUL: alu_req.op = rpn_pkg::ALU_MUL;
      rpn_pkg::OP_DIV: alu_req.op = rpn_pkg::ALU_DIV;
      default:         alu_req.op = rpn_pkg::ALU_ADD;
    endcase
    unique case (state_q)
      rpn_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          tok_d = in_data_i;
        end
      end
      rpn_pkg::CS_DECODE: begin
        unique case (tok_q.op) inside
          rpn_pkg::OP_NUM: begin
            if (cnt_q >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH)) begin
              cnt_d = '0;
              rsp_d = '{status: rpn_pkg::ST_OVERFLOW, result_value: '0};
            end else begin
              stk_req.wr_en   = 1'b1;
              stk_req.wr_addr = cnt_q[rpn_pkg::SP_W-1:0];
              stk_req.wr_data = tok_q.value;
              tos_d = tok_q.value;
              cnt_d = cnt_q + 1'b1;
              rsp_d = '{status: rpn_pkg::ST_OK, result_value: tok_q.value};
            end
          end
          rpn_pkg::OP_END: begin
            cnt_d = '0;
            if (cnt_q != rpn_pkg::CNT_W'(1)) begin
              rsp_d = '{status: rpn_pkg::ST_BADEND, result_value: '0};
            end else begin
              rsp_d = '{status: rpn_pkg::ST_FINAL, result_value: tos_q};
            end
          end
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
            if (cnt_q < rpn_pkg::CNT_W'(2)) begin
              cnt_d = '0;
              rsp_d = '{status: rpn_pkg::ST_FEW, result_value: '0};
            end else if (!bin_ok) begin
              cnt_d = '0;
              rsp_d = '{status: rpn_pkg::ST_DIVZERO, result_value: '0};
            end else begin
              stk_req.rd_en   = 1'b1;
              stk_req.rd_addr = below_idx;
            end
          end
          default: begin
            rsp_d.status       = rpn_pkg::ST_OK;
            rsp_d.result_value = (cnt_q == '0) ? '0 : tos_q;
          end
        endcase
      end
      rpn_pkg::CS_LOAD: begin
        alu_req.start = 1'b1;
      end
      rpn_pkg::CS_EXEC: begin
        if (alu_done) begin
          stk_req.wr_en   = 1'b1;
          stk_req.wr_addr = below_idx;
          stk_req.wr_data = alu_result;
          tos_d = alu_result;
          cnt_d = cnt_q - 1'b1;
          rsp_d = '{status: rpn_pkg::ST_OK, result_value: alu_result};
        end
      end
      rpn_pkg::CS_RESP: begin
        if (out_free) begin
          out_d       = rsp_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpn_pkg::CS_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    tos_q <= tos_d;
    rsp_q <= rsp_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != rpn_pkg::CS_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The operand count never passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
    else $error("operand count exceeds stack depth");

  // The arithmetic unit only finishes while the sequencer waits for it.
  a_alu_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == rpn_pkg::CS_EXEC))
    else $error("arithmetic result arrived outside the execute state");

  // A new output beat is only loaded from the response state.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rpn_pkg::CS_RESP))
    else $error("output beat loaded outside the response state");

  // Every error beat carries a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == rpn_pkg::ST_FEW
                     || out_q.status == rpn_pkg::ST_DIVZERO
                     || out_q.status == rpn_pkg::ST_OVERFLOW
                     || out_q.status == rpn_pkg::ST_BADEND))
    |-> (out_q.result_value == '0))
    else $error("error beat with a nonzero value");

endmodule
